>>> design/wcd_pkg.sv
// wcd_pkg: widths, constants, calendar table and shared types for the
// week-of-year calendar dates block. No dependencies.
package wcd_pkg;

  localparam int YearW      = 14;
  localparam int WeekW      = 6;
  localparam int MonthW     = 4;
  localparam int DayW       = 5;
  localparam int WdayW      = 3;
  localparam int DoyW       = 9;
  localparam int QuotW      = 8;   // year / 100 for a 14-bit year
  localparam int RemW       = 7;   // year % 100
  localparam int SumW       = 15;  // weekday sum before mod 7
  localparam int DigSumW    = 6;   // sum of five octal digits
  localparam int RecipW     = 13;
  localparam int ProdW      = YearW + RecipW;
  localparam int NumStages  = 4;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam logic [RecipW-1:0] Recip100      = RecipW'(5243);
  localparam int                Recip100Shift = 19;

  localparam logic [WeekW-1:0] WeekMin = WeekW'(1);
  localparam logic [WeekW-1:0] WeekMax = WeekW'(53);

  localparam logic [DoyW-1:0] DaysCommonYear = DoyW'(365);
  localparam logic [DoyW-1:0] DaysLeapYear   = DoyW'(366);
  localparam logic [SumW-1:0] YearShift      = SumW'(399);

  localparam logic [DoyW-1:0] DaysBeforeMonth [12] = '{
    DoyW'(0),   DoyW'(31),  DoyW'(59),  DoyW'(90),  DoyW'(120), DoyW'(151),
    DoyW'(181), DoyW'(212), DoyW'(243), DoyW'(273), DoyW'(304), DoyW'(334)
  };

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } md_t;

  // facts about the year, handed from the year stages to the date stages
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [DoyW-1:0]  week_end;
    logic             leap;
    logic             leap_next;
    logic [SumW-1:0]  wsum;
    logic             err;
  } yr_t;

  typedef struct packed {
    logic [WdayW-1:0]  start_weekday;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [WdayW-1:0]  end_weekday;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic [YearW-1:0]  end_year;
    logic              input_error;
  } res_t;

  // day of year to month and day of month, parallel compares against the table
  function automatic md_t split_doy(input logic [DoyW-1:0] doy, input logic leap);
    md_t             res;
    logic [DoyW-1:0] prior_days;
    logic            found;
    res.month = MonthW'(1);
    res.day   = DayW'(doy);
    found     = 1'b0;
    for (int m = 11; m >= 0; m--) begin
      prior_days = DaysBeforeMonth[m] + DoyW'((leap && (m >= 2)) ? 1 : 0);
      if (!found && (doy > prior_days)) begin
        found     = 1'b1;
        res.month = MonthW'(m + 1);
        res.day   = DayW'(doy - prior_days);
      end
    end
    return res;
  endfunction

endpackage

>>> design/wcd_if.sv
// wcd_in_if / wcd_out_if: valid-ready channels for requests and results.
// Depends on wcd_pkg.
interface wcd_in_if;
  import wcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [YearW-1:0] year_number;
  logic [WeekW-1:0] week_number;

  modport source (output valid, year_number, week_number, input ready);
  modport sink   (input valid, year_number, week_number, output ready);
endinterface

interface wcd_out_if;
  import wcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WdayW-1:0]  start_weekday;
  logic [MonthW-1:0] start_month;
  logic [DayW-1:0]   start_day;
  logic [WdayW-1:0]  end_weekday;
  logic [MonthW-1:0] end_month;
  logic [DayW-1:0]   end_day;
  logic [YearW-1:0]  end_year;
  logic              input_error;

  modport source (output valid, start_weekday, start_month, start_day, end_weekday,
                  end_month, end_day, end_year, input_error, input ready);
  modport sink   (input valid, start_weekday, start_month, start_day, end_weekday,
                  end_month, end_day, end_year, input_error, output ready);
endinterface

>>> design/week_of_year_calendar_dates_core.sv
// Week-of-year calendar dates: for a Gregorian year and week number N gives
// the weekday of January 1 (also the week's first weekday), the month and day
// of day-of-year 7N-6, and month, day, year and weekday of day 7N.
// Requests come in on req_i (year_number, week_number); results leave on rsp_o.
// An item moves on a rising edge where valid and ready are both high.
// Four register stages: reciprocal multiply for year / 100, leap and weekday
// sums, mod 7 and year spill, month split into the result register;
// rsp_o.valid rises when an accepted item reaches the result register.
// Throughput: one item per cycle; all stages advance together whenever the
// result register is empty or its item is being taken.
// When rsp_o.ready is low with a result waiting, the whole pipe holds and
// req_i.ready drops; nothing is lost or repeated.
// A week number outside 1..53 gives input_error with all other fields zero.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
// Depends on wcd_pkg, wcd_if, wcd_year, wcd_date.
module week_of_year_calendar_dates_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcd_in_if.sink    req_i,
  wcd_out_if.source rsp_o
);
  import wcd_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic                 en;
  yr_t                  yr;
  res_t                 res;

  assign en    = !vld_q[NumStages-1] || rsp_o.ready;
  assign vld_d = {vld_q[NumStages-2:0], req_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  wcd_year u_year (
    .clk_i  (clk_i),
    .en_i   (en),
    .year_i (req_i.year_number),
    .week_i (req_i.week_number),
    .yr_o   (yr)
  );

  wcd_date u_date (
    .clk_i (clk_i),
    .en_i  (en),
    .yr_i  (yr),
    .res_o (res)
  );

  assign req_i.ready         = en;
  assign rsp_o.valid         = vld_q[NumStages-1];
  assign rsp_o.start_weekday = res.start_weekday;
  assign rsp_o.start_month   = res.start_month;
  assign rsp_o.start_day     = res.start_day;
  assign rsp_o.end_weekday   = res.end_weekday;
  assign rsp_o.end_month     = res.end_month;
  assign rsp_o.end_day       = res.end_day;
  assign rsp_o.end_year      = res.end_year;
  assign rsp_o.input_error   = res.input_error;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.input_error |->
      rsp_o.start_month == '0 && rsp_o.end_month == '0 && rsp_o.end_year == '0
      && rsp_o.start_weekday == '0 && rsp_o.end_day == '0)
    else $error("error result carries nonzero fields");

  a_end_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.input_error |->
      rsp_o.start_weekday < WdayW'(7) &&
      ((rsp_o.start_weekday == '0 && rsp_o.end_weekday == WdayW'(6)) ||
       (rsp_o.start_weekday != '0 &&
        rsp_o.end_weekday == rsp_o.start_weekday - WdayW'(1))))
    else $error("end weekday not one before start weekday");

  a_same_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.input_error && rsp_o.start_month == rsp_o.end_month |->
      rsp_o.end_day == rsp_o.start_day + DayW'(6))
    else $error("week within one month does not span six days");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during a stall");
`endif

endmodule

>>> design/wcd_year.sv
// wcd_year: pipeline stages 1 and 2, year / 100 by reciprocal multiply,
// leap tests for the year and the next one, weekday sum. Depends on wcd_pkg.
module wcd_year (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [wcd_pkg::YearW-1:0] year_i,
  input  logic [wcd_pkg::WeekW-1:0] week_i,
  output wcd_pkg::yr_t              yr_o
);
  import wcd_pkg::*;

  // stage 1
  logic [YearW-1:0] s1_year_q;
  logic [ProdW-1:0] s1_prod_q;
  logic [DoyW-1:0]  s1_week_end_q;
  logic             s1_err_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_year_q     <= year_i;
      s1_prod_q     <= ProdW'(year_i) * ProdW'(Recip100);
      s1_week_end_q <= DoyW'({week_i, 3'b000}) - DoyW'(week_i);
      s1_err_q      <= (week_i < WeekMin) || (week_i > WeekMax);
    end
  end

  // stage 2
  logic [QuotW-1:0] quot;
  logic [QuotW-1:0] quot_next;
  logic [YearW-1:0] quot_x100;
  logic [RemW-1:0]  rem;
  logic             rem_zero;
  logic             rem_99;
  logic [1:0]       year_next_lo;
  logic [SumW-1:0]  shifted;
  logic [QuotW-1:0] shifted_quot;
  yr_t              yr_d;
  yr_t              yr_q;

  always_comb begin
    quot         = s1_prod_q[Recip100Shift +: QuotW];
    quot_x100    = (YearW'(quot) << 6) + (YearW'(quot) << 5) + (YearW'(quot) << 2);
    rem          = RemW'(s1_year_q - quot_x100);
    rem_zero     = (rem == '0);
    rem_99       = (rem == RemW'(99));
    quot_next    = quot + QuotW'(rem_99);
    year_next_lo = s1_year_q[1:0] + 2'd1;
    // (y + 399) / 100 is quot + 3, or quot + 4 when the remainder is nonzero
    shifted      = SumW'(s1_year_q) + YearShift;
    shifted_quot = quot + (rem_zero ? QuotW'(3) : QuotW'(4));

    yr_d.year      = s1_year_q;
    yr_d.week_end  = s1_week_end_q;
    yr_d.err       = s1_err_q;
    yr_d.leap      = (s1_year_q[1:0] == 2'd0) && (!rem_zero || (quot[1:0] == 2'd0));
    yr_d.leap_next = (year_next_lo == 2'd0) && (!rem_99 || (quot_next[1:0] == 2'd0));
    // 365 == 1 mod 7, so a * 365 contributes a
    yr_d.wsum      = SumW'(1) + shifted + (shifted >> 2) - SumW'(shifted_quot)
                   + SumW'(shifted_quot >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yr_q <= yr_d;
    end
  end

  assign yr_o = yr_q;

endmodule

>>> design/wcd_date.sv
// wcd_date: pipeline stages 3 and 4, weekday mod 7, spill into the next year,
// month and day split, result register. Depends on wcd_pkg.
module wcd_date (
  input  logic          clk_i,
  input  logic          en_i,
  input  wcd_pkg::yr_t  yr_i,
  output wcd_pkg::res_t res_o
);
  import wcd_pkg::*;

  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] val);
    logic [DigSumW-1:0] acc;
    // 8 == 1 mod 7, so octal digits add up
    acc = DigSumW'(val[2:0]) + DigSumW'(val[5:3]) + DigSumW'(val[8:6])
        + DigSumW'(val[11:9]) + DigSumW'(val[14:12]);
    if (acc >= DigSumW'(28)) acc = acc - DigSumW'(28);
    if (acc >= DigSumW'(14)) acc = acc - DigSumW'(14);
    if (acc >= DigSumW'(7))  acc = acc - DigSumW'(7);
    return WdayW'(acc);
  endfunction

  // stage 3
  logic [WdayW-1:0]  s3_wd_q, s3_wd_d;
  logic [WdayW-1:0]  s3_ewd_q, s3_ewd_d;
  logic [DoyW-1:0]   s3_sdoy_q, s3_sdoy_d;
  logic [DoyW-1:0]   s3_edoy_q, s3_edoy_d;
  logic              s3_leap_q;
  logic              s3_eleap_q, s3_eleap_d;
  logic [YearW-1:0]  s3_eyear_q, s3_eyear_d;
  logic              s3_err_q;
  logic [DoyW-1:0]   year_len;
  logic              spill;

  always_comb begin
    s3_wd_d    = mod7(yr_i.wsum);
    s3_ewd_d   = (s3_wd_d == '0) ? WdayW'(6) : s3_wd_d - WdayW'(1);
    year_len   = yr_i.leap ? DaysLeapYear : DaysCommonYear;
    spill      = yr_i.week_end > year_len;
    s3_sdoy_d  = yr_i.week_end - DoyW'(6);
    s3_edoy_d  = spill ? yr_i.week_end - year_len : yr_i.week_end;
    s3_eyear_d = spill ? yr_i.year + YearW'(1) : yr_i.year;
    s3_eleap_d = spill ? yr_i.leap_next : yr_i.leap;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_wd_q    <= s3_wd_d;
      s3_ewd_q   <= s3_ewd_d;
      s3_sdoy_q  <= s3_sdoy_d;
      s3_edoy_q  <= s3_edoy_d;
      s3_leap_q  <= yr_i.leap;
      s3_eleap_q <= s3_eleap_d;
      s3_eyear_q <= s3_eyear_d;
      s3_err_q   <= yr_i.err;
    end
  end

  // stage 4, result register
  md_t  start_md;
  md_t  end_md;
  res_t res_d;
  res_t res_q;

  always_comb begin
    start_md = split_doy(s3_sdoy_q, s3_leap_q);
    end_md   = split_doy(s3_edoy_q, s3_eleap_q);
    res_d    = '0;
    if (s3_err_q) begin
      res_d.input_error = 1'b1;
    end else begin
      res_d.start_weekday = s3_wd_q;
      res_d.start_month   = start_md.month;
      res_d.start_day     = start_md.day;
      res_d.end_weekday   = s3_ewd_q;
      res_d.end_month     = end_md.month;
      res_d.end_day       = end_md.day;
      res_d.end_year      = s3_eyear_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
